>>> design/fbsm_pkg.sv
package fbsm_pkg;

    localparam int NUM_BLOCKS       = 256;
    localparam int PAGES_PER_BLOCK  = 64;
    localparam int SECTORS_PER_PAGE = 4;
    localparam int SECT_PER_BLK     = PAGES_PER_BLOCK * SECTORS_PER_PAGE;
    localparam int TOTAL_SECTS      = NUM_BLOCKS * SECT_PER_BLK;

    localparam int BLK_AW  = $clog2(NUM_BLOCKS);
    localparam int SECT_AW = $clog2(TOTAL_SECTS);
    localparam int INB_W   = $clog2(SECT_PER_BLK);
    localparam int SPP_W   = $clog2(SECTORS_PER_PAGE);
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 16;

    localparam logic [31:0] ERASE_LIMIT = 32'd9999999;
    localparam logic [31:0] LSN_NONE    = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] FREE_TOTAL_MAX = 9'd511;
    localparam logic [CNT_W-1:0] NB_MAX         = 9'd256;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_INV   = 3'd2;
    localparam logic [2:0] MODE_ERASE = 3'd3;
    localparam logic [2:0] MODE_ALLOC = 3'd4;
    localparam logic [2:0] MODE_PROBE = 3'd5;

    localparam logic [1:0] GC_NORMAL  = 2'd0;
    localparam logic [1:0] GC_COLLECT = 2'd1;
    localparam logic [1:0] GC_FILTER  = 2'd2;
    localparam logic [1:0] GC_MIGRATE = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RANGE      = 4'd1;
    localparam logic [3:0] ST_UNWRITTEN  = 4'd2;
    localparam logic [3:0] ST_NOT_FREE   = 4'd3;
    localparam logic [3:0] ST_NOT_VALID  = 4'd4;
    localparam logic [3:0] ST_MISMATCH   = 4'd5;
    localparam logic [3:0] ST_RESERVE    = 4'd6;
    localparam logic [3:0] ST_NONE_FREE  = 4'd7;
    localparam logic [3:0] ST_UNALIGNED  = 4'd8;

    localparam logic [1:0] PS_FREE    = 2'd0;
    localparam logic [1:0] PS_VALID   = 2'd1;
    localparam logic [1:0] PS_INVALID = 2'd2;

    localparam logic CFG_MIN_FREE = 1'b0;
    localparam logic CFG_BLOCKS   = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] sector_address;
        logic [7:0]  block_index;
        logic [31:0] lsn_0;
        logic [31:0] lsn_1;
        logic [31:0] lsn_2;
        logic [31:0] lsn_3;
        logic [3:0]  lsn_present;
        logic        map_page;
        logic [1:0]  gc_kind;
    } fbsm_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  sector_count;
        logic [31:0] out_lsn_0;
        logic [31:0] out_lsn_1;
        logic [31:0] out_lsn_2;
        logic [31:0] out_lsn_3;
        logic [3:0]  out_present;
        logic [7:0]  chosen_block;
        logic [1:0]  page_state;
    } fbsm_out_t;

    typedef struct packed {
        logic        written;
        logic        valid;
        logic [31:0] logical;
    } sec_ent_t;

    typedef struct packed {
        logic        free;
        logic [31:0] ecount;
    } blk_ent_t;

    localparam sec_ent_t SEC_CLEAR = '{written: 1'b0, valid: 1'b0, logical: LSN_NONE};
    localparam blk_ent_t BLK_RESET = '{free: 1'b1, ecount: 32'd0};

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_BLK_RD,
        S_BLK_CHK,
        S_ALLOC_END,
        S_SEC_RD,
        S_SEC_CHK,
        S_SEC_WR,
        S_CLR,
        S_BLK_WR,
        S_DONE
    } fsm_state_t;

endpackage

>>> design/fbsm_ram.sv
module fbsm_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/flash_block_state_manager.sv
// Flash block status table.
// cmd channel (cmd_valid/cmd_ready/cmd) takes one command word; rsp channel
// (rsp_valid/rsp_ready/rsp) returns exactly one result word per command.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the reserve
// (index 0) or the managed block count (index 1, also reloads the free
// block total); it is always ready.
// A sequencer steps one sector/block table port for each command and hands
// the result over to the result register.
// Allocation scans the block table once, reading one entry at a time through
// a single compare unit; erase clears the block's sectors one per cycle.
// After reset all 65536 sector table entries are cleared, one a cycle;
// cmd_ready stays low meanwhile. The block table uses reset-cleared
// valid bits instead.
// A result waits in the output register while rsp_ready is low; the next
// command is taken meanwhile, but its result is held until the register frees.
module flash_block_state_manager
    import fbsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  fbsm_in_t  cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output fbsm_out_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [8:0] cfg_data
);

    fsm_state_t state_reg, state_next;
    fbsm_in_t   cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]  status_reg, status_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] olsn_reg [SECTORS_PER_PAGE];
    logic [31:0] olsn_next [SECTORS_PER_PAGE];
    logic [3:0]  opres_reg, opres_next;
    logic [7:0]  chosen_reg, chosen_next;
    logic [1:0]  pstate_reg, pstate_next;
    logic [31:0] best_reg, best_next;
    logic        found_reg, found_next;
    logic        hit_reg, hit_next;
    logic [CNT_W-1:0] min_free_reg, blocks_reg, fbt_reg, fbt_next;
    logic [NUM_BLOCKS-1:0] blk_vld_reg;
    logic        rsp_valid_reg;
    fbsm_out_t   rsp_reg;

    logic [CNT_W-1:0] nb;
    logic [CNT_W-1:0] cfg_nb;
    logic             pbn_out;
    logic             aligned;
    logic [31:0]      lsn_arr [SECTORS_PER_PAGE];
    logic [SPP_W-1:0] sub;
    logic             sub_pres;
    logic             sub_last;

    logic             sec_we;
    logic [SECT_AW-1:0] sec_waddr, sec_raddr;
    sec_ent_t         sec_wdata, sec_rdata;
    logic             blk_we;
    logic [BLK_AW-1:0] blk_waddr, blk_raddr;
    blk_ent_t         blk_wdata, blk_rdata, blk_ent;
    logic             sec_direct;
    logic             done_load;

    assign nb       = (blocks_reg > NB_MAX) ? NB_MAX : blocks_reg;
    assign cfg_nb   = (cfg_data > NB_MAX) ? NB_MAX : cfg_data;
    assign pbn_out  = {1'b0, cmd_reg.sector_address[SECT_AW-1:INB_W]} >= nb;
    assign aligned  = cmd_reg.sector_address[SPP_W-1:0] == '0;
    assign lsn_arr[0] = cmd_reg.lsn_0;
    assign lsn_arr[1] = cmd_reg.lsn_1;
    assign lsn_arr[2] = cmd_reg.lsn_2;
    assign lsn_arr[3] = cmd_reg.lsn_3;
    assign sub      = idx_reg[SPP_W-1:0];
    assign sub_pres = cmd_reg.lsn_present[sub];
    assign sub_last = sub == SPP_W'(SECTORS_PER_PAGE - 1);
    assign sec_direct = (cmd_reg.mode == MODE_INV) || (cmd_reg.mode == MODE_PROBE);
    assign blk_ent  = blk_vld_reg[blk_raddr] ? blk_rdata : BLK_RESET;
    assign done_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    fbsm_ram #(.WIDTH($bits(sec_ent_t)), .DEPTH(TOTAL_SECTS)) u_sec_ram
    (
        .clk   (clk),
        .we    (sec_we),
        .waddr (sec_waddr),
        .wdata (sec_wdata),
        .raddr (sec_raddr),
        .rdata (sec_rdata)
    );

    fbsm_ram #(.WIDTH($bits(blk_ent_t)), .DEPTH(NUM_BLOCKS)) u_blk_ram
    (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    // Memory and handshake controls
    always_comb
    begin
        cmd_ready = state_reg == S_IDLE;
        cfg_ready = 1'b1;
        sec_we    = 1'b0;
        sec_wdata = SEC_CLEAR;
        sec_raddr = sec_direct ? cmd_reg.sector_address
                               : {cmd_reg.sector_address[SECT_AW-1:SPP_W], sub};
        sec_waddr = sec_raddr;
        blk_we    = 1'b0;
        blk_wdata = BLK_RESET;
        blk_waddr = cmd_reg.block_index;
        if (cmd_reg.mode == MODE_ALLOC)
        begin
            blk_raddr = idx_reg[BLK_AW-1:0];
        end
        else if (cmd_reg.mode == MODE_ERASE)
        begin
            blk_raddr = cmd_reg.block_index;
        end
        else
        begin
            blk_raddr = cmd_reg.sector_address[SECT_AW-1:INB_W];
        end
        unique case (state_reg)
            S_INIT:
            begin
                sec_we    = 1'b1;
                sec_waddr = idx_reg[SECT_AW-1:0];
            end
            S_SEC_CHK:
            begin
                // invalidate writes back with the valid flag dropped
                if (cmd_reg.mode == MODE_INV && sec_rdata.written && sec_rdata.valid
                    && sec_rdata.logical == cmd_reg.lsn_0)
                begin
                    sec_we    = 1'b1;
                    sec_wdata = '{written: 1'b1, valid: 1'b0, logical: sec_rdata.logical};
                end
            end
            S_SEC_WR:
            begin
                sec_we    = sub_pres;
                sec_wdata = '{written: 1'b1, valid: 1'b1, logical: lsn_arr[sub]};
            end
            S_CLR:
            begin
                sec_we    = 1'b1;
                sec_waddr = {cmd_reg.block_index, idx_reg[INB_W-1:0]};
            end
            S_BLK_WR:
            begin
                blk_we    = 1'b1;
                blk_wdata = '{free: 1'b1,
                              ecount: (best_reg == LSN_NONE) ? best_reg : best_reg + 32'd1};
            end
            S_ALLOC_END:
            begin
                blk_we    = found_reg;
                blk_waddr = chosen_reg;
                blk_wdata = '{free: 1'b0, ecount: best_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        count_next  = count_reg;
        olsn_next   = olsn_reg;
        opres_next  = opres_reg;
        chosen_next = chosen_reg;
        pstate_next = pstate_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        fbt_next    = fbt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(TOTAL_SECTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    idx_next    = '0;
                    status_next = ST_OK;
                    count_next  = '0;
                    for (int i = 0; i < SECTORS_PER_PAGE; i++)
                    begin
                        olsn_next[i] = '0;
                    end
                    opres_next  = '0;
                    chosen_next = '0;
                    pstate_next = PS_FREE;
                    best_next   = ERASE_LIMIT;
                    found_next  = 1'b0;
                    hit_next    = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority case (cmd_reg.mode)
                    MODE_WRITE, MODE_READ:
                    begin
                        if (pbn_out)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (!aligned)
                        begin
                            status_next = ST_UNALIGNED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = (cmd_reg.mode == MODE_READ) ? S_BLK_RD : S_SEC_RD;
                        end
                    end
                    MODE_INV, MODE_PROBE:
                    begin
                        if (pbn_out)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SEC_RD;
                        end
                    end
                    MODE_ERASE:
                    begin
                        if ({1'b0, cmd_reg.block_index} >= nb)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_BLK_RD;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        if (cmd_reg.gc_kind == GC_NORMAL && min_free_reg >= fbt_reg)
                        begin
                            status_next = ST_RESERVE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_BLK_RD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_BLK_RD:
            begin
                state_next = S_BLK_CHK;
            end
            S_BLK_CHK:
            begin
                if (cmd_reg.mode == MODE_ALLOC)
                begin
                    if (blk_ent.free && blk_ent.ecount < best_reg)
                    begin
                        best_next   = blk_ent.ecount;
                        chosen_next = idx_reg[BLK_AW-1:0];
                        found_next  = 1'b1;
                    end
                    if (idx_reg[CNT_W-1:0] == nb - 9'd1)
                    begin
                        state_next = S_ALLOC_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BLK_RD;
                    end
                end
                else if (blk_ent.free)
                begin
                    status_next = ST_UNWRITTEN;
                    state_next  = S_DONE;
                end
                else if (cmd_reg.mode == MODE_ERASE)
                begin
                    best_next  = blk_ent.ecount;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_SEC_RD;
                end
            end
            S_ALLOC_END:
            begin
                if (!found_reg)
                begin
                    status_next = ST_NONE_FREE;
                end
                else if (fbt_reg != '0)
                begin
                    fbt_next = fbt_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_SEC_RD:
            begin
                state_next = S_SEC_CHK;
            end
            S_SEC_CHK:
            begin
                state_next = S_DONE;
                priority case (cmd_reg.mode)
                    MODE_WRITE:
                    begin
                        if (sub_last)
                        begin
                            if (hit_reg || (sub_pres && sec_rdata.written))
                            begin
                                status_next = ST_NOT_FREE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SEC_WR;
                            end
                        end
                        else
                        begin
                            hit_next   = hit_reg || (sub_pres && sec_rdata.written);
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_SEC_RD;
                        end
                    end
                    MODE_READ:
                    begin
                        if (cmd_reg.gc_kind == GC_COLLECT || cmd_reg.gc_kind == GC_MIGRATE)
                        begin
                            if (sec_rdata.written && sec_rdata.valid)
                            begin
                                olsn_next[count_reg[SPP_W-1:0]]  = sec_rdata.logical;
                                opres_next[count_reg[SPP_W-1:0]] = 1'b1;
                                count_next = count_reg + 3'd1;
                            end
                        end
                        else if (sub_pres)
                        begin
                            if (!(sec_rdata.written && sec_rdata.valid))
                            begin
                                if (cmd_reg.gc_kind != GC_FILTER)
                                begin
                                    status_next = ST_NOT_VALID;
                                end
                            end
                            else if (sec_rdata.logical != lsn_arr[sub])
                            begin
                                status_next = ST_MISMATCH;
                            end
                            else
                            begin
                                olsn_next[sub]  = sec_rdata.logical;
                                opres_next[sub] = 1'b1;
                                count_next = count_reg + 3'd1;
                            end
                        end
                        if (status_next != ST_OK)
                        begin
                            // a failing check drops everything gathered so far
                            count_next = '0;
                            opres_next = '0;
                            for (int i = 0; i < SECTORS_PER_PAGE; i++)
                            begin
                                olsn_next[i] = '0;
                            end
                        end
                        else if (!sub_last)
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_SEC_RD;
                        end
                    end
                    MODE_INV:
                    begin
                        if (!(sec_rdata.written && sec_rdata.valid))
                        begin
                            status_next = ST_NOT_VALID;
                        end
                        else if (sec_rdata.logical != cmd_reg.lsn_0)
                        begin
                            status_next = ST_MISMATCH;
                        end
                    end
                    default:
                    begin
                        if (!sec_rdata.written)
                        begin
                            pstate_next = PS_FREE;
                        end
                        else
                        begin
                            pstate_next = sec_rdata.valid ? PS_VALID : PS_INVALID;
                        end
                    end
                endcase
            end
            S_SEC_WR:
            begin
                if (sub_pres)
                begin
                    count_next = count_reg + 3'd1;
                end
                if (sub_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CLR:
            begin
                if (idx_reg[INB_W-1:0] == INB_W'(SECT_PER_BLK - 1))
                begin
                    state_next = S_BLK_WR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_BLK_WR:
            begin
                if (fbt_reg < FREE_TOTAL_MAX)
                begin
                    fbt_next = fbt_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (done_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_valid && cfg_index == CFG_BLOCKS)
        begin
            fbt_next = cfg_nb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            min_free_reg  <= 9'd4;
            blocks_reg    <= NB_MAX;
            fbt_reg       <= NB_MAX;
            blk_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fbt_reg   <= fbt_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MIN_FREE)
                begin
                    min_free_reg <= cfg_data;
                end
                else
                begin
                    blocks_reg <= cfg_data;
                end
            end
            if (blk_we)
            begin
                blk_vld_reg[blk_waddr] <= 1'b1;
            end
            if (done_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        olsn_reg   <= olsn_next;
        opres_reg  <= opres_next;
        chosen_reg <= chosen_next;
        pstate_reg <= pstate_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
        if (done_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.sector_count <= count_reg;
            rsp_reg.out_lsn_0    <= olsn_reg[0];
            rsp_reg.out_lsn_1    <= olsn_reg[1];
            rsp_reg.out_lsn_2    <= olsn_reg[2];
            rsp_reg.out_lsn_3    <= olsn_reg[3];
            rsp_reg.out_present  <= opres_reg;
            rsp_reg.chosen_block <= chosen_reg;
            rsp_reg.page_state   <= pstate_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> dv/flash_block_state_manager_tb.sv
`timescale 1ns / 100ps

module flash_block_state_manager_tb;
    import fbsm_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    fbsm_in_t   cmd = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    fbsm_out_t  rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [8:0] cfg_data = '0;

    // shadow copy of the status table
    bit          sec_written[TOTAL_SECTS];
    bit          sec_valid[TOTAL_SECTS];
    logic [31:0] sec_lsn[TOTAL_SECTS];
    bit          blk_free[NUM_BLOCKS];
    logic [31:0] blk_erases[NUM_BLOCKS];
    int unsigned free_total;
    int unsigned reserve_cfg;
    int unsigned blocks_cfg;

    fbsm_out_t   expected_rsp[$];
    int          error_count = 0;
    int          burst_left = 0;
    int          hold_cycles = 0;

    flash_block_state_manager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned live_blocks();
        return (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : blocks_cfg;
    endfunction

    function automatic void reset_table();
        for (int s = 0; s < TOTAL_SECTS; s++)
        begin
            sec_written[s] = 1'b0;
            sec_valid[s] = 1'b0;
            sec_lsn[s] = LSN_NONE;
        end
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            blk_free[b] = 1'b1;
            blk_erases[b] = '0;
        end
        reserve_cfg = 4;
        blocks_cfg = 256;
        free_total = 256;
    endfunction

    function automatic fbsm_out_t apply_command(fbsm_in_t c);
        fbsm_out_t   o;
        logic [31:0] lsn[4];
        logic [31:0] olsn[4];
        int unsigned nb, pbn, sa, s, cnt, best;
        logic [3:0]  pres;
        bit          found;
        o = '0;
        lsn[0] = c.lsn_0;
        lsn[1] = c.lsn_1;
        lsn[2] = c.lsn_2;
        lsn[3] = c.lsn_3;
        for (int i = 0; i < 4; i++)
            olsn[i] = '0;
        nb = live_blocks();
        sa = c.sector_address;
        pbn = sa / SECT_PER_BLK;
        cnt = 0;
        pres = '0;
        case (c.mode)
            MODE_WRITE:
            begin
                if (pbn >= nb)
                    o.status = ST_RANGE;
                else if (sa[1:0] != 0)
                    o.status = ST_UNALIGNED;
                else
                begin
                    for (int i = 0; i < 4; i++)
                        if (c.lsn_present[i] && sec_written[sa + i])
                            o.status = ST_NOT_FREE;
                    if (o.status == ST_OK)
                        for (int i = 0; i < 4; i++)
                            if (c.lsn_present[i])
                            begin
                                sec_written[sa + i] = 1'b1;
                                sec_valid[sa + i] = 1'b1;
                                sec_lsn[sa + i] = lsn[i];
                                cnt++;
                            end
                end
            end
            MODE_READ:
            begin
                if (pbn >= nb)
                    o.status = ST_RANGE;
                else if (sa[1:0] != 0)
                    o.status = ST_UNALIGNED;
                else if (blk_free[pbn])
                    o.status = ST_UNWRITTEN;
                else if (c.gc_kind == GC_COLLECT || c.gc_kind == GC_MIGRATE)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        s = sa + i;
                        if (sec_written[s] && sec_valid[s])
                        begin
                            olsn[cnt] = sec_lsn[s];
                            pres[cnt] = 1'b1;
                            cnt++;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        s = sa + i;
                        if (o.status == ST_OK && c.lsn_present[i])
                        begin
                            if (!(sec_written[s] && sec_valid[s]))
                            begin
                                if (c.gc_kind == GC_NORMAL)
                                    o.status = ST_NOT_VALID;
                            end
                            else if (sec_lsn[s] != lsn[i])
                                o.status = ST_MISMATCH;
                            else
                            begin
                                olsn[i] = lsn[i];
                                pres[i] = 1'b1;
                                cnt++;
                            end
                        end
                    end
                end
                if (o.status != ST_OK)
                begin
                    cnt = 0;
                    pres = '0;
                    for (int i = 0; i < 4; i++)
                        olsn[i] = '0;
                end
            end
            MODE_INV:
            begin
                if (pbn >= nb)
                    o.status = ST_RANGE;
                else if (!sec_written[sa] || !sec_valid[sa])
                    o.status = ST_NOT_VALID;
                else if (sec_lsn[sa] != lsn[0])
                    o.status = ST_MISMATCH;
                else
                    sec_valid[sa] = 1'b0;
            end
            MODE_ERASE:
            begin
                if (c.block_index >= nb)
                    o.status = ST_RANGE;
                else if (blk_free[c.block_index])
                    o.status = ST_UNWRITTEN;
                else
                begin
                    blk_free[c.block_index] = 1'b1;
                    for (int i = 0; i < SECT_PER_BLK; i++)
                    begin
                        s = c.block_index * SECT_PER_BLK + i;
                        sec_written[s] = 1'b0;
                        sec_valid[s] = 1'b0;
                        sec_lsn[s] = LSN_NONE;
                    end
                    if (blk_erases[c.block_index] != LSN_NONE)
                        blk_erases[c.block_index]++;
                    if (free_total < 511)
                        free_total++;
                end
            end
            MODE_ALLOC:
            begin
                if (c.gc_kind == GC_NORMAL && reserve_cfg >= free_total)
                    o.status = ST_RESERVE;
                else
                begin
                    best = ERASE_LIMIT;
                    found = 1'b0;
                    for (int b = 0; b < nb; b++)
                        if (blk_free[b] && blk_erases[b] < best)
                        begin
                            best = blk_erases[b];
                            o.chosen_block = 8'(b);
                            found = 1'b1;
                        end
                    if (!found)
                    begin
                        o.status = ST_NONE_FREE;
                        o.chosen_block = '0;
                    end
                    else
                    begin
                        blk_free[o.chosen_block] = 1'b0;
                        if (free_total > 0)
                            free_total--;
                    end
                end
            end
            MODE_PROBE:
            begin
                if (pbn >= nb)
                    o.status = ST_RANGE;
                else if (!sec_written[sa])
                    o.page_state = PS_FREE;
                else
                    o.page_state = sec_valid[sa] ? PS_VALID : PS_INVALID;
            end
            default:
                o.status = ST_RANGE;
        endcase
        o.sector_count = 3'(cnt);
        o.out_present = pres;
        o.out_lsn_0 = olsn[0];
        o.out_lsn_1 = olsn[1];
        o.out_lsn_2 = olsn[2];
        o.out_lsn_3 = olsn[3];
        return o;
    endfunction

    // offer one word, then maybe end the burst with an idle gap
    task automatic send_cmd(fbsm_in_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        expected_rsp.push_back(apply_command(c));
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        // keep idling after the last response before moving on
        repeat (600)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_MIN_FREE)
            reserve_cfg = data;
        else
        begin
            blocks_cfg = data;
            free_total = live_blocks();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic fbsm_in_t make_cmd();
        fbsm_in_t    c;
        int unsigned r, nb, blk, sa;
        c.lsn_0 = $urandom;
        c.lsn_1 = $urandom;
        c.lsn_2 = $urandom;
        c.lsn_3 = $urandom;
        c.lsn_present = ($urandom_range(0, 99) < 55) ? 4'hF : 4'($urandom_range(0, 15));
        c.map_page = 1'($urandom_range(0, 1));
        c.gc_kind = 2'($urandom_range(0, 3));
        c.block_index = 8'($urandom_range(0, 255));
        nb = live_blocks();
        blk = $urandom_range(0, (nb < 12 ? nb : 12) - 1);
        if ($urandom_range(0, 99) < 10)
            sa = $urandom_range(0, 65535);
        else
            sa = blk * SECT_PER_BLK + $urandom_range(0, 7) * 4;
        r = $urandom_range(0, 99);
        if (r < 30)
            c.mode = MODE_WRITE;
        else if (r < 55)
            c.mode = MODE_READ;
        else if (r < 67)
        begin
            c.mode = MODE_INV;
            sa = (sa + $urandom_range(0, 3)) & 16'hFFFF;
        end
        else if (r < 75)
            c.mode = MODE_ERASE;
        else if (r < 87)
            c.mode = MODE_ALLOC;
        else if (r < 97)
            c.mode = MODE_PROBE;
        else
            c.mode = 3'($urandom_range(6, 7));
        c.sector_address = 16'(sa);
        if ($urandom_range(0, 99) < 75 && (c.mode == MODE_READ || c.mode == MODE_INV))
        begin
            // echo the stored numbers so the checks get past the first sector
            c.lsn_0 = sec_lsn[sa];
            c.lsn_1 = sec_lsn[(sa + 1) & 16'hFFFF];
            c.lsn_2 = sec_lsn[(sa + 2) & 16'hFFFF];
            c.lsn_3 = sec_lsn[(sa + 3) & 16'hFFFF];
        end
        if (c.mode == MODE_ERASE && $urandom_range(0, 99) < 80)
            c.block_index = 8'(blk);
        return c;
    endfunction

    function automatic fbsm_in_t mk(logic [2:0] m, logic [15:0] sa, logic [7:0] bi,
                                    logic [31:0] l0, logic [3:0] pres, logic [1:0] gck);
        fbsm_in_t c;
        c = '0;
        c.mode = m;
        c.sector_address = sa;
        c.block_index = bi;
        c.lsn_0 = l0;
        c.lsn_1 = ~l0;
        c.lsn_2 = 32'h1234_5678;
        c.lsn_3 = LSN_NONE;
        c.lsn_present = pres;
        c.map_page = m[0];
        c.gc_kind = gck;
        return c;
    endfunction

    task automatic test_directed();
        send_cmd(mk(MODE_PROBE, 16'hFFFF, 8'd0, '0, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_READ, 16'h0000, 8'd0, '0, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_ALLOC, '0, '0, '0, '0, GC_NORMAL));
        send_cmd(mk(MODE_WRITE, 16'h0000, 8'd0, 32'd0, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_WRITE, 16'h0000, 8'd0, 32'd7, 4'h1, GC_NORMAL));
        send_cmd(mk(MODE_WRITE, 16'h0002, 8'd0, 32'd7, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_WRITE, 16'h0004, 8'd0, LSN_NONE, 4'h5, GC_NORMAL));
        send_cmd(mk(MODE_READ, 16'h0000, 8'd0, 32'd0, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_READ, 16'h0000, 8'd0, 32'd1, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_READ, 16'h0004, 8'd0, LSN_NONE, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_READ, 16'h0004, 8'd0, '0, 4'h0, GC_COLLECT));
        send_cmd(mk(MODE_READ, 16'h0004, 8'd0, LSN_NONE, 4'hF, GC_FILTER));
        send_cmd(mk(MODE_READ, 16'h0000, 8'd0, '0, 4'h0, GC_MIGRATE));
        send_cmd(mk(MODE_READ, 16'h0001, 8'd0, '0, 4'hF, GC_NORMAL));
        send_cmd(mk(MODE_INV, 16'h0001, 8'd0, 32'hFFFF_FFFF, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_INV, 16'h0001, 8'd0, 32'd9, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_INV, 16'h0000, 8'd0, 32'd0, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_INV, 16'h0000, 8'd0, 32'd0, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_PROBE, 16'h0000, 8'd0, '0, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_PROBE, 16'h0001, 8'd0, '0, 4'h0, GC_NORMAL));
        send_cmd(mk(MODE_ERASE, '0, 8'd255, '0, '0, GC_NORMAL));
        send_cmd(mk(MODE_ERASE, '0, 8'd0, '0, '0, GC_NORMAL));
        send_cmd(mk(3'd6, 16'hFFFF, 8'hFF, LSN_NONE, 4'hF, GC_MIGRATE));
        send_cmd(mk(3'd7, '0, '0, '0, '0, GC_NORMAL));
    endtask

    task automatic test_random(logic [8:0] reserve, logic [8:0] blocks, int count);
        write_reg(CFG_MIN_FREE, reserve);
        write_reg(CFG_BLOCKS, blocks);
        repeat (count)
            send_cmd(make_cmd());
    endtask

    task automatic test_backpressure();
        fbsm_in_t c;
        drain();
        hold_cycles = 400;
        repeat (40)
        begin
            c = make_cmd();
            c.mode = MODE_PROBE;
            send_cmd(c);
        end
    endtask

    // receiver: long hold when asked, else one of four ready patterns in turn
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case (($time / 256) % 4)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ready <= ($urandom_range(0, 1) != 0);
                default: rsp_ready <= (($time / 4) % 3 != 0);
            endcase
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        fbsm_out_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, rsp);
                error_count++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                check_field("status", e.status, rsp.status);
                check_field("sector_count", e.sector_count, rsp.sector_count);
                check_field("out_lsn_0", e.out_lsn_0, rsp.out_lsn_0);
                check_field("out_lsn_1", e.out_lsn_1, rsp.out_lsn_1);
                check_field("out_lsn_2", e.out_lsn_2, rsp.out_lsn_2);
                check_field("out_lsn_3", e.out_lsn_3, rsp.out_lsn_3);
                check_field("out_present", e.out_present, rsp.out_present);
                check_field("chosen_block", e.chosen_block, rsp.chosen_block);
                check_field("page_state", e.page_state, rsp.page_state);
            end
        end
    end

    initial
    begin
        reset_table();
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(9'd4, 9'd256, 300);
        test_random(9'd0, 9'd8, 250);
        test_random(9'd256, 9'd300, 180);
        test_random(9'd2, 9'd1, 120);
        test_backpressure();
        test_random(9'd511, 9'd16, 100);
        test_random(9'd4, 9'd256, 150);
        drain();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
design/fbsm_pkg.sv
design/fbsm_ram.sv
design/flash_block_state_manager.sv
dv/flash_block_state_manager_tb.sv
